FILE: design/unique_id_allocator_assert.svh
`ifndef UNIQUE_ID_ALLOCATOR_ASSERT_SVH
`define UNIQUE_ID_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define UIDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/uida_pkg.sv
package uida_pkg;

  localparam int SET_CAPACITY = 64;
  localparam int ID_W         = 32;
  localparam int RANGE_W      = 12;
  localparam int RANGE_SHIFT  = 20;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // stored entry handed from one cell to the next on insert
  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
  } entry_t;

  // probe travelling down the chain
  typedef struct packed {
    logic            pv;
    logic            hit;
    logic [ID_W-1:0] cand;
  } probe_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic flush;
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

FILE: design/unique_id_allocator.sv
// mark: one probe walks the whole cell chain, then its result goes to the output register;
// allocate: candidates enter the chain from the cursor up, one per cycle, and the first to leave
// the tail without a hit wins; clear, unknown commands and allocate on a full set skip the chain
// one item at a time: the next is taken the cycle after the result loads, and the result
// loads into the output register only once that register has room
// reset (rst_n, synchronous, active low): set empty, cursor 1, no result pending
module unique_id_allocator #(
  parameter int SET_CAPACITY = uida_pkg::SET_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [uida_pkg::ID_W-1:0]    in_id_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [uida_pkg::ID_W-1:0]    out_new_id,
  output logic                         out_status,
  // range register write
  input  logic                         cfg_wr_en,
  input  logic [uida_pkg::RANGE_W-1:0] cfg_id_range
);

`include "unique_id_allocator_assert.svh"

  // one-hot controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_RESP   = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [uida_pkg::ID_W-1:0] cursor_r, cursor_nxt;
  logic [uida_pkg::ID_W-1:0] inj_r, inj_nxt;        // next candidate for allocate
  logic                      alloc_r, alloc_nxt;    // current search is an allocate
  logic [uida_pkg::ID_W-1:0] pend_new_id_r, pend_new_id_nxt;
  logic                      pend_status_r, pend_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [uida_pkg::ID_W-1:0] out_new_id_r, out_new_id_nxt;
  logic                      out_status_r, out_status_nxt;

  // chain wiring: index 0 feeds the first cell, index SET_CAPACITY is the tail
  uida_pkg::entry_t          ent_w [0:SET_CAPACITY];
  uida_pkg::probe_t          prb_w [0:SET_CAPACITY];
  uida_pkg::cell_ctl_t       ctl;
  uida_pkg::probe_t          inj;
  logic [uida_pkg::ID_W-1:0] ins_id;
  uida_pkg::probe_t          tail;
  logic                      full;
  logic                      out_free;
  logic [uida_pkg::ID_W-1:0] range_cur;
  uida_pkg::cmd_t            cmd;

  // ---------------------------------------------------------------------------
  // cell chain: entries fill from cell 0 by shifting, so valid bits form a
  // prefix and the last cell's valid bit says the set is full; probes walk one
  // cell per cycle and collect a hit flag against every stored entry
  // ---------------------------------------------------------------------------
  assign ent_w[0] = '{vld: 1'b1, id: ins_id};
  assign prb_w[0] = inj;

  for (genvar g = 0; g < SET_CAPACITY; g++) begin : g_cell
    uida_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl),
      .ent_i (ent_w[g]),
      .ent_o (ent_w[g+1]),
      .prb_i (prb_w[g]),
      .prb_o (prb_w[g+1])
    );
  end

  assign tail     = prb_w[SET_CAPACITY];
  assign full     = ent_w[SET_CAPACITY].vld;
  assign out_free = !out_valid_r || !out_stall;
  assign cmd      = uida_pkg::cmd_t'(in_command);

  // cursor load value from the range register, zero maps to one
  assign range_cur = {cfg_id_range, {uida_pkg::RANGE_SHIFT{1'b0}}};

  // ---------------------------------------------------------------------------
  // controller
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    cursor_nxt      = cursor_r;
    inj_nxt         = inj_r;
    alloc_nxt       = alloc_r;
    pend_new_id_nxt = pend_new_id_r;
    pend_status_nxt = pend_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_new_id_nxt  = out_new_id_r;
    out_status_nxt  = out_status_r;
    ctl             = '0;
    inj             = '0;
    ins_id          = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            uida_pkg::CMD_ALLOC: begin
              if (full) begin
                // nothing to hand out
                pend_new_id_nxt = '0;
                pend_status_nxt = 1'b1;
                state_nxt       = ST_RESP;
              end else begin
                // first candidate is the cursor itself
                inj       = '{pv: 1'b1, hit: 1'b0, cand: cursor_r};
                inj_nxt   = cursor_r + 1'b1;
                alloc_nxt = 1'b1;
                state_nxt = ST_SEARCH;
              end
            end
            uida_pkg::CMD_MARK: begin
              // single membership probe for the given id
              inj       = '{pv: 1'b1, hit: 1'b0, cand: in_id_value};
              alloc_nxt = 1'b0;
              state_nxt = ST_SEARCH;
            end
            uida_pkg::CMD_CLEAR: begin
              ctl.clear       = 1'b1;
              pend_new_id_nxt = '0;
              pend_status_nxt = 1'b0;
              state_nxt       = ST_RESP;
            end
            default: begin
              // unknown command leaves the set and cursor alone and replies with status 0
              pend_new_id_nxt = '0;
              pend_status_nxt = 1'b0;
              state_nxt       = ST_RESP;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // allocate keeps streaming consecutive candidates (wrapping mod 2^32)
        if (alloc_r) begin
          inj     = '{pv: 1'b1, hit: 1'b0, cand: inj_r};
          inj_nxt = inj_r + 1'b1;
        end
        if (tail.pv) begin
          if (alloc_r) begin
            // first candidate out of the tail without a hit wins
            if (!tail.hit) begin
              ctl.flush       = 1'b1;
              ctl.shift       = 1'b1;
              ins_id          = tail.cand;
              cursor_nxt      = tail.cand;
              pend_new_id_nxt = tail.cand;
              pend_status_nxt = 1'b0;
              state_nxt       = ST_RESP;
            end
          end else begin
            ctl.flush       = 1'b1;
            pend_new_id_nxt = '0;
            if (tail.hit) begin
              // duplicate, ignored
              pend_status_nxt = 1'b0;
            end else if (full) begin
              pend_status_nxt = 1'b1;
            end else begin
              ctl.shift       = 1'b1;
              ins_id          = tail.cand;
              pend_status_nxt = 1'b0;
            end
            state_nxt = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        // move the result into the output register once it has room
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_new_id_nxt = pend_new_id_r;
          out_status_nxt = pend_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // range write is only to be done while idle; the block itself does not enforce it
    if (cfg_wr_en) begin
      cursor_nxt = (range_cur == '0) ? {{(uida_pkg::ID_W-1){1'b0}}, 1'b1} : range_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= {{(uida_pkg::ID_W-1){1'b0}}, 1'b1};
      alloc_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      alloc_r     <= alloc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    inj_r         <= inj_nxt;
    pend_new_id_r <= pend_new_id_nxt;
    pend_status_r <= pend_status_nxt;
    out_new_id_r  <= out_new_id_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_new_id = out_new_id_r;
  assign out_status = out_status_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // probes only live while a search is running
  `UIDA_ASSERT_NOW(a_probe_in_search, tail.pv, state_r == ST_SEARCH, "probe at tail outside search")
  // full status only reported while the set really is full
  `UIDA_ASSERT_NOW(a_full_status, state_r == ST_RESP && pend_status_r, full, "full status with room left")
  // entries fill from the head, so a full chain has its first entry valid
  `UIDA_ASSERT_NOW(a_fill_prefix, ent_w[SET_CAPACITY].vld, ent_w[1].vld, "valid bits not a prefix")
  // a clear leaves the set empty
  `UIDA_ASSERT_NEXT(a_clear_empty, state_r == ST_IDLE && in_valid && cmd == uida_pkg::CMD_CLEAR, !ent_w[1].vld && !full, "set not empty after clear")

endmodule

FILE: design/uida_cell.sv
module uida_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  uida_pkg::cell_ctl_t ctl_i,
  input  uida_pkg::entry_t   ent_i,
  output uida_pkg::entry_t   ent_o,
  input  uida_pkg::probe_t   prb_i,
  output uida_pkg::probe_t   prb_o
);

  logic                      vld_r;
  logic [uida_pkg::ID_W-1:0] id_r;
  logic                      pv_r;
  logic                      hit_r;
  logic [uida_pkg::ID_W-1:0] cand_r;
  logic                      match;

  assign match = vld_r && (id_r == prb_i.cand);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      pv_r  <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        vld_r <= 1'b0;
      end else if (ctl_i.shift) begin
        vld_r <= ent_i.vld;
      end
      pv_r <= prb_i.pv && !ctl_i.flush;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (ctl_i.shift) begin
      id_r <= ent_i.id;
    end
    cand_r <= prb_i.cand;
    hit_r  <= prb_i.hit || match;
  end

  assign ent_o = '{vld: vld_r, id: id_r};
  assign prb_o = '{pv: pv_r, hit: hit_r, cand: cand_r};

endmodule

FILE: dv/tb.sv
module tb;
  import uida_pkg::*;

  // cycles with no item moving on either channel before the run is abandoned
  localparam int IDLE_LIMIT  = 4000;
  // long receiver hold-off used to back the block up
  localparam int HOLD_CYCLES = 500;
  // settle time after the last reply, above the worst allocate latency
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [ID_W-1:0] new_id;
    logic            status;
  } id_reply_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [1:0]          in_command   = CMD_CLEAR;
  logic [ID_W-1:0]     in_id_value  = '0;
  logic                out_valid;
  logic                out_stall    = 1'b1;
  logic [ID_W-1:0]     out_new_id;
  logic                out_status;
  logic                cfg_wr_en    = 1'b0;
  logic [RANGE_W-1:0]  cfg_id_range = '0;

  // predicted allocator state
  logic [ID_W-1:0] taken_ids[$];
  logic [ID_W-1:0] id_cursor;
  id_reply_t       replies_due[$];

  int  errors      = 0;
  int  idle_cycles = 0;
  bit  bubbles_on  = 1'b1;
  int  hold_seq    = 0;
  int  hold_seen   = 0;
  int  stall_left  = 0;
  int  stall_roll;

  unique_id_allocator i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_id_value  (in_id_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_new_id   (out_new_id),
    .out_status   (out_status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_id_range (cfg_id_range)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic bit is_taken(logic [ID_W-1:0] v);
    foreach (taken_ids[k]) begin
      if (taken_ids[k] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one command to the predicted set and returns the reply it owes
  function automatic id_reply_t next_free_reply(cmd_t c, logic [ID_W-1:0] v);
    id_reply_t       r;
    logic [ID_W-1:0] cand;
    r.new_id = '0;
    r.status = 1'b0;
    case (c)
      CMD_ALLOC: begin
        if (taken_ids.size() >= SET_CAPACITY) begin
          // full set: nothing handed out, cursor stays
          r.status = 1'b1;
        end else begin
          // walk up from the cursor, wrapping past all ones
          cand = id_cursor;
          while (is_taken(cand)) cand = cand + 32'd1;
          taken_ids.push_back(cand);
          id_cursor = cand;
          r.new_id  = cand;
        end
      end
      CMD_MARK: begin
        // a duplicate is silently accepted even on a full set
        if (!is_taken(v)) begin
          if (taken_ids.size() >= SET_CAPACITY) r.status = 1'b1;
          else taken_ids.push_back(v);
        end
      end
      CMD_CLEAR: begin
        // cursor is left where it was
        taken_ids.delete();
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (!bubbles_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // values close to the cursor make later allocates probe longer, members give duplicates
  function automatic logic [ID_W-1:0] pick_mark_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return id_cursor + $urandom_range(0, 80);
    if (roll < 7 && taken_ids.size() != 0)
      return taken_ids[$urandom_range(0, taken_ids.size() - 1)];
    return $urandom();
  endfunction

  // offers one item and waits until the block takes it; valid stays high
  // so back-to-back items need no extra edge
  task automatic offer_command(cmd_t c, logic [ID_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= c;
    in_id_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(next_free_reply(c, v));
  endtask

  // every item owes exactly one reply, so an empty queue means an idle block
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_range(logic [RANGE_W-1:0] r);
    logic [ID_W-1:0] c;
    cfg_wr_en    <= 1'b1;
    cfg_id_range <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    c = {r, {RANGE_SHIFT{1'b0}}};
    id_cursor = (c == '0) ? 32'd1 : c;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked sequence from range zero: probing past marked ids,
  // duplicates, field extremes, clear keeping the cursor
  task automatic test_basic();
    write_range('0);
    offer_command(CMD_ALLOC, '0);
    offer_command(CMD_ALLOC, 32'hFFFF_FFFF);
    offer_command(CMD_MARK, 32'd3);
    offer_command(CMD_ALLOC, '0);
    offer_command(CMD_MARK, 32'd3);
    offer_command(CMD_MARK, 32'd0);
    offer_command(CMD_MARK, 32'hFFFF_FFFF);
    offer_command(CMD_ALLOC, '0);
    offer_command(CMD_CLEAR, 32'hFFFF_FFFF);
    offer_command(CMD_ALLOC, '0);
    offer_command(CMD_MARK, 32'd5);
    offer_command(CMD_ALLOC, '0);
    wait_drained();
  endtask

  // top and bottom of the range register, plus range one
  task automatic test_range_extremes();
    write_range(12'hFFF);
    offer_command(CMD_ALLOC, '0);
    offer_command(CMD_MARK, 32'hFFF0_0001);
    offer_command(CMD_MARK, 32'hFFF0_0002);
    offer_command(CMD_ALLOC, '0);
    offer_command(CMD_CLEAR, '0);
    wait_drained();
    write_range(12'd1);
    offer_command(CMD_ALLOC, '0);
    wait_drained();
    write_range('0);
    offer_command(CMD_ALLOC, '0);
    wait_drained();
  endtask

  // fill the set to capacity, then poke it while full
  task automatic test_full_set(int rounds);
    int n;
    for (int k = 0; k < rounds; k++) begin
      offer_command(CMD_CLEAR, $urandom());
      while (taken_ids.size() < SET_CAPACITY) begin
        if ($urandom_range(0, 2) == 0) offer_command(CMD_ALLOC, $urandom());
        else offer_command(CMD_MARK, pick_mark_value());
      end
      n = $urandom_range(4, 10);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0:       offer_command(CMD_ALLOC, $urandom());
          1:       offer_command(CMD_MARK, $urandom());
          default: offer_command(CMD_MARK, pick_mark_value());
        endcase
      end
    end
  endtask

  // random mix of commands; clear roughly once every clear_odds items
  task automatic test_random_mix(int n, int clear_odds);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1, clear_odds) == 1) offer_command(CMD_CLEAR, $urandom());
      else if ($urandom_range(0, 99) < 45) offer_command(CMD_ALLOC, $urandom());
      else offer_command(CMD_MARK, pick_mark_value());
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    bubbles_on <= 1'b0;
    hold_seq   <= hold_seq + 1;
    test_random_mix(30, 10);
    bubbles_on <= 1'b1;
  endtask

  // no idling on either side
  task automatic test_no_gaps(int n);
    bubbles_on <= 1'b0;
    @(posedge clk);
    test_random_mix(n, 15);
    bubbles_on <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
    $display("tb: mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver stall: a requested long hold first, otherwise random, or none while bubbles are off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      stall_left <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!bubbles_on) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 60) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 50);
      end
    end
  end

  // each accepted reply against the oldest one owed
  always @(posedge clk) begin
    id_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected reply new_id", out_new_id, '0);
      end else begin
        want = replies_due.pop_front();
        if (out_new_id !== want.new_id) report_mismatch("new_id", out_new_id, want.new_id);
        if (out_status !== want.status)
          report_mismatch("status", {31'b0, out_status}, {31'b0, want.status});
      end
    end
  end

  // watchdog on cycles in which no item moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    taken_ids.delete();
    id_cursor = 32'd1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic();
    test_range_extremes();

    test_random_mix(500, 30);
    wait_drained();

    write_range(12'hFFF);
    test_full_set(7);
    wait_drained();

    write_range('0);
    test_backpressure();
    wait_drained();

    write_range(RANGE_W'($urandom_range(1, 4094)));
    test_random_mix(450, 20);
    wait_drained();

    write_range(RANGE_W'($urandom_range(1, 4094)));
    test_full_set(3);
    test_no_gaps(150);
    wait_drained();

    write_range('0);
    test_random_mix(200, 40);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/uida_pkg.sv
design/uida_cell.sv
design/unique_id_allocator.sv
dv/tb.sv
